// ----- rtl/n50_length_statistic_macros.svh -----
// Assertion macros for the N50 length statistic block.
// No dependencies; included by files that carry concurrent assertions.
`ifndef N50_LENGTH_STATISTIC_MACROS_SVH
`define N50_LENGTH_STATISTIC_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define N50_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define N50_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Condition that must never hold outside reset.
`define N50_ASSERT_NEVER(label, cond, msg) \
  `N50_ASSERT_IMPL(label, 1'b1, !(cond), msg)

`endif

// ----- rtl/n50_pkg.sv -----
// Shared constants, types and state codes for the N50 length statistic block.
// No dependencies; imported by the interfaces and every module.
package n50_pkg;

  localparam int MAX_READS     = 1024;
  localparam int LENGTH_BITS   = 32;
  localparam int READ_LENGTH_W = 32;
  localparam int N50_LENGTH_W  = 32;
  localparam int CNT_W         = $clog2(MAX_READS + 1);
  localparam int SUM_W         = LENGTH_BITS + CNT_W;
  localparam int STAT_N        = 4;
  localparam int FLUSH_CYCLES  = 2;

  // statistic codes
  localparam logic [1:0] STAT_PH_ALL = 2'd0;
  localparam logic [1:0] STAT_PH_PH  = 2'd1;
  localparam logic [1:0] STAT_UN_ALL = 2'd2;
  localparam logic [1:0] STAT_UN_UN  = 2'd3;

  typedef enum logic [2:0] {
    S_LOAD,
    S_DRAIN,
    S_WALK,
    S_FLUSH,
    S_EMIT
  } state_t;

  // length travelling down the chain
  typedef struct packed {
    logic                   valid;
    logic [LENGTH_BITS-1:0] len;
    logic                   phased;
  } token_t;

  // length held in a cell
  typedef struct packed {
    logic                   occ;
    logic [LENGTH_BITS-1:0] len;
    logic                   phased;
  } entry_t;

  typedef struct packed {
    logic clear;
    logic pop;
  } chain_ctrl_t;

  typedef struct packed {
    logic clear;
    logic feed;
  } walk_ctrl_t;

  typedef struct packed {
    logic                   found;
    logic [LENGTH_BITS-1:0] len;
  } n50_res_t;

endpackage

// ----- rtl/n50_read_if.sv -----
// Input channel: one read length word per handshake.
// Depends on n50_pkg.
interface n50_read_if import n50_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [READ_LENGTH_W-1:0] read_length;
  logic                     is_phased;
  logic                     last_read;

  modport source (output valid, read_length, is_phased, last_read, input ready);
  modport sink   (input valid, read_length, is_phased, last_read, output ready);
endinterface

// ----- rtl/n50_result_if.sv -----
// Result channel: one N50 statistic word per handshake.
// Depends on n50_pkg.
interface n50_result_if import n50_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [1:0]              statistic;
  logic [N50_LENGTH_W-1:0] n50_length;
  logic                    found;
  logic                    overflowed;
  logic                    last_result;

  modport source (output valid, statistic, n50_length, found, overflowed, last_result,
                  input ready);
  modport sink   (input valid, statistic, n50_length, found, overflowed, last_result,
                  output ready);
endinterface

// ----- rtl/n50_cell.sv -----
// One sorter cell: keeps the larger of its entry and the arriving length,
// hands the smaller one on. In pop mode it takes its right neighbor's entry.
// Depends on n50_pkg.
module n50_cell import n50_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  chain_ctrl_t ctrl,
  input  token_t      tok_in,
  input  entry_t      right,
  output token_t      tok_out,
  output entry_t      held
);

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      held.occ      <= 1'b0;
      tok_out.valid <= 1'b0;
    end else if (ctrl.pop) begin
      held          <= right;
      tok_out.valid <= 1'b0;
    end else if (tok_in.valid) begin
      if (!held.occ || tok_in.len > held.len) begin
        held.occ       <= 1'b1;
        held.len       <= tok_in.len;
        held.phased    <= tok_in.phased;
        tok_out.valid  <= held.occ;
        tok_out.len    <= held.len;
        tok_out.phased <= held.phased;
      end else begin
        tok_out <= tok_in;
      end
    end else begin
      tok_out.valid <= 1'b0;
    end
  end

endmodule

// ----- rtl/n50_chain.sv -----
// Row of sorter cells holding all loaded lengths in descending order.
// Depends on n50_pkg and n50_cell.
module n50_chain import n50_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  chain_ctrl_t ctrl,
  input  token_t      tok_in,
  output entry_t      head,
  output logic        spill
);

  token_t tok [MAX_READS+1];
  entry_t ent [MAX_READS+1];

  assign tok[0]         = tok_in;
  assign ent[MAX_READS] = '0;
  assign head           = ent[0];
  // a length falling off the end would mean a lost read
  assign spill          = tok[MAX_READS].valid;

  for (genvar g = 0; g < MAX_READS; g++) begin : g_cell
    n50_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl),
      .tok_in  (tok[g]),
      .right   (ent[g+1]),
      .tok_out (tok[g+1]),
      .held    (ent[g])
    );
  end

endmodule

// ----- rtl/n50_walk.sv -----
// Walk over the sorted lengths: running sums per class, compared against
// half of the class total and half of the grand total.
// Depends on n50_pkg.
module n50_walk import n50_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  walk_ctrl_t       ctrl,
  input  entry_t           head,
  input  logic [SUM_W-1:0] phased_sum,
  input  logic [SUM_W-1:0] unphased_sum,
  output n50_res_t         res [STAT_N]
);

  logic [SUM_W:0]         grand;
  logic [SUM_W-1:0]       thr_all;
  logic [SUM_W-1:0]       thr_ph;
  logic [SUM_W-1:0]       thr_un;
  logic [SUM_W-1:0]       run_ph;
  logic [SUM_W-1:0]       run_un;
  logic                   b_valid;
  logic [LENGTH_BITS-1:0] b_len;
  logic                   b_phased;

  assign grand = {1'b0, phased_sum} + {1'b0, unphased_sum};

  // sums are stable for the whole walk
  always_ff @(posedge clk) begin
    thr_all <= grand[SUM_W:1];
    thr_ph  <= phased_sum >> 1;
    thr_un  <= unphased_sum >> 1;
  end

  // stage 1: accumulate
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      run_ph  <= '0;
      run_un  <= '0;
      b_valid <= 1'b0;
    end else begin
      b_valid <= ctrl.feed;
      if (ctrl.feed) begin
        b_len    <= head.len;
        b_phased <= head.phased;
        if (head.phased) begin
          run_ph <= run_ph + {{CNT_W{1'b0}}, head.len};
        end else begin
          run_un <= run_un + {{CNT_W{1'b0}}, head.len};
        end
      end
    end
  end

  // stage 2: first crossing of each threshold
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      for (int k = 0; k < STAT_N; k++) begin
        res[k] <= '0;
      end
    end else if (b_valid) begin
      if (b_phased) begin
        if (!res[STAT_PH_ALL].found && run_ph >= thr_all) begin
          res[STAT_PH_ALL] <= '{found: 1'b1, len: b_len};
        end
        if (!res[STAT_PH_PH].found && run_ph >= thr_ph) begin
          res[STAT_PH_PH] <= '{found: 1'b1, len: b_len};
        end
      end else begin
        if (!res[STAT_UN_ALL].found && run_un >= thr_all) begin
          res[STAT_UN_ALL] <= '{found: 1'b1, len: b_len};
        end
        if (!res[STAT_UN_UN].found && run_un >= thr_un) begin
          res[STAT_UN_UN] <= '{found: 1'b1, len: b_len};
        end
      end
    end
  end

endmodule

// ----- rtl/n50_length_statistic.sv -----
// N50 length statistic over phased and unphased reads.
// reads: one word per read (length, phase tag, last marker), ready only while
// loading. Each accepted word is inserted into a row of MAX_READS sorter
// cells; words past MAX_READS are dropped and set the overflowed flag. The
// word with last_read set closes the run: the chain settles (S_DRAIN), is
// popped head first while the class sums are walked (S_WALK), and once the
// walk pipeline has drained (S_FLUSH) four result words follow in statistic
// order 0..3, the fourth with last_result set. Run time is bound by the
// single pop port at the head of the chain and the insert rate of one word
// per cycle while loading.
// results: each word is held until taken; a stalled receiver simply holds the
// block in the result phase and no new read is accepted meanwhile. After the
// fourth word all counts, sums and flags clear and loading resumes.
// Reset (rst, synchronous) empties the chain and clears all counts at once;
// the block is ready for reads in the next cycle.
// Depends on n50_pkg, n50_read_if, n50_result_if, n50_chain, n50_walk, n50_length_statistic_macros.svh.
`include "n50_length_statistic_macros.svh"

module n50_length_statistic import n50_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  n50_read_if.sink     reads,
  n50_result_if.source results
);

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] read_count;
  logic [CNT_W-1:0] cnt;
  logic [SUM_W-1:0] phased_sum;
  logic [SUM_W-1:0] unphased_sum;
  logic             overflow_flag;
  logic [1:0]       emit_idx;

  logic        in_fire;
  logic        room;
  logic        ins;
  logic        out_fire;
  logic        end_run;
  logic        spill;
  token_t      tok_in;
  entry_t      head;
  chain_ctrl_t chain_ctrl;
  walk_ctrl_t  walk_ctrl;
  n50_res_t    res [STAT_N];
  n50_res_t    sel;

  assign in_fire  = reads.valid && reads.ready;
  assign room     = read_count < CNT_W'(MAX_READS);
  assign ins      = in_fire && room;
  assign out_fire = results.valid && results.ready;
  assign end_run  = out_fire && emit_idx == STAT_UN_UN;
  assign tok_in   = '{valid: ins, len: reads.read_length[LENGTH_BITS-1:0],
                      phased: reads.is_phased};

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_LOAD:  if (in_fire && reads.last_read) state_next = S_DRAIN;
      S_DRAIN: if (cnt == read_count) state_next = S_WALK;
      S_WALK:  if (cnt == read_count) state_next = S_FLUSH;
      S_FLUSH: if (cnt == CNT_W'(FLUSH_CYCLES - 1)) state_next = S_EMIT;
      S_EMIT:  if (end_run) state_next = S_LOAD;
      default: state_next = S_LOAD;
    endcase
  end

  // outputs
  always_comb begin
    reads.ready      = 1'b0;
    results.valid    = 1'b0;
    chain_ctrl.pop   = 1'b0;
    chain_ctrl.clear = end_run;
    walk_ctrl.clear  = end_run;
    case (state)
      S_LOAD:  reads.ready = 1'b1;
      S_WALK:  chain_ctrl.pop = cnt != read_count;
      S_EMIT:  results.valid = 1'b1;
      default: ;
    endcase
    walk_ctrl.feed = chain_ctrl.pop;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= (state_next != state) ? '0 : cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || end_run) begin
      read_count    <= '0;
      phased_sum    <= '0;
      unphased_sum  <= '0;
      overflow_flag <= 1'b0;
      emit_idx      <= STAT_PH_ALL;
    end else begin
      if (ins) begin
        read_count <= read_count + 1'b1;
        if (reads.is_phased) begin
          phased_sum <= phased_sum + {{CNT_W{1'b0}}, tok_in.len};
        end else begin
          unphased_sum <= unphased_sum + {{CNT_W{1'b0}}, tok_in.len};
        end
      end else if (in_fire) begin
        overflow_flag <= 1'b1;
      end
      if (out_fire) begin
        emit_idx <= emit_idx + 1'b1;
      end
    end
  end

  n50_chain u_chain (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (chain_ctrl),
    .tok_in (tok_in),
    .head   (head),
    .spill  (spill)
  );

  n50_walk u_walk (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (walk_ctrl),
    .head         (head),
    .phased_sum   (phased_sum),
    .unphased_sum (unphased_sum),
    .res          (res)
  );

  assign sel                 = res[emit_idx];
  assign results.statistic   = emit_idx;
  assign results.n50_length  = sel.found ? N50_LENGTH_W'(sel.len) : '0;
  assign results.found       = sel.found;
  assign results.overflowed  = overflow_flag;
  assign results.last_result = emit_idx == STAT_UN_UN;

  `N50_ASSERT_IMPL(a_pop_occupied, chain_ctrl.pop, head.occ, "popped an empty cell")
  `N50_ASSERT_NEVER(a_no_spill, spill, "length fell off the end of the chain")
  `N50_ASSERT_NEVER(a_count_range, read_count > CNT_W'(MAX_READS), "read count past capacity")
  `N50_ASSERT_NEXT(a_load_closes, in_fire && reads.last_read, !reads.ready, "load open after last word")

endmodule
